### rtl/dscw_pkg.sv
// Shared types, constants and tables for the date string checker.
`default_nettype none

package dscw_pkg;

  // Character codes and string positions
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [3:0] POS_SEP0 = 4'd4;
  localparam logic [3:0] POS_SEP1 = 4'd7;
  localparam logic [3:0] POS_LAST = 4'd9;
  localparam logic [3:0] POS_END  = 4'd10;
  localparam logic [3:0] POS_SAT  = 4'd11;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 7;
  localparam int DAY_W  = 7;
  localparam int SUM_W  = 15;

  // x / 100 == (x * 5243) >> 19 for x below 43690
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SHR = 19;
  // x / 7 == (x * 18725) >> 17 for x below 43690
  localparam logic [14:0] DIV7_MUL   = 15'd18725;
  localparam int          DIV7_SHR   = 17;

  localparam logic [MON_W-1:0] MON_FEB = 7'd2;
  localparam logic [MON_W-1:0] MON_DEC = 7'd12;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic              fmt_ok;
  } date_t;

  typedef struct packed {
    logic              date_ok;
    logic [SUM_W-1:0]  sum;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } wsum_t;

  // Days in a common year; zero for month codes outside 1..12
  function automatic logic [4:0] month_len(input logic [MON_W-1:0] m);
    logic [4:0] len;
    case (m)
      7'd1:    len = 5'd31;
      7'd2:    len = 5'd28;
      7'd3:    len = 5'd31;
      7'd4:    len = 5'd30;
      7'd5:    len = 5'd31;
      7'd6:    len = 5'd30;
      7'd7:    len = 5'd31;
      7'd8:    len = 5'd31;
      7'd9:    len = 5'd30;
      7'd10:   len = 5'd31;
      7'd11:   len = 5'd30;
      7'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // floor(26 * (shifted month + 1) / 10); January and February count as 13 and 14
  function automatic logic [5:0] month_term(input logic [MON_W-1:0] m);
    logic [5:0] t;
    case (m)
      7'd1:    t = 6'd36;
      7'd2:    t = 6'd39;
      7'd3:    t = 6'd10;
      7'd4:    t = 6'd13;
      7'd5:    t = 6'd15;
      7'd6:    t = 6'd18;
      7'd7:    t = 6'd20;
      7'd8:    t = 6'd23;
      7'd9:    t = 6'd26;
      7'd10:   t = 6'd28;
      7'd11:   t = 6'd31;
      7'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/dscw_parse.sv
// Input register, character parser and per-string date snapshot register.
`default_nettype none

module dscw_parse (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] char_code
  input  wire logic               in_tlast,   // last
  output logic                    date_valid,
  input  wire logic               date_ready,
  output dscw_pkg::date_t         date
);
  import dscw_pkg::*;

  logic              in_v_r;
  logic [7:0]        in_char_r;
  logic              in_last_r;

  logic [3:0]        pos_r, pos_nxt;
  logic              fmt_bad_r, fmt_bad_nxt;
  logic [YEAR_W-1:0] year_acc_r, year_acc_nxt;
  logic [MON_W-1:0]  month_acc_r, month_acc_nxt;
  logic [DAY_W-1:0]  day_acc_r, day_acc_nxt;

  logic              date_v_r;
  date_t             date_r;

  logic              date_free;
  logic              consume;
  logic              is_digit;
  logic [3:0]        dig;

  assign date_free = !date_v_r || date_ready;
  // A closing character waits until the snapshot register is free
  assign consume   = in_v_r && (!in_last_r || date_free);
  assign in_tready = !in_v_r || consume;

  assign is_digit = (in_char_r > CH_SLASH) && (in_char_r < CH_COLON);
  assign dig      = in_char_r[3:0];

  always_comb begin
    pos_nxt       = (pos_r < POS_SAT) ? 4'(pos_r + 4'd1) : pos_r;
    fmt_bad_nxt   = fmt_bad_r;
    year_acc_nxt  = year_acc_r;
    month_acc_nxt = month_acc_r;
    day_acc_nxt   = day_acc_r;
    if (pos_r >= POS_END) begin
      fmt_bad_nxt = 1'b1;
    end else if (pos_r == POS_SEP0 || pos_r == POS_SEP1) begin
      if (in_char_r != CH_SLASH) begin
        fmt_bad_nxt = 1'b1;
      end
    end else if (!is_digit) begin
      fmt_bad_nxt = 1'b1;
    end else if (pos_r < POS_SEP0) begin
      year_acc_nxt = YEAR_W'(year_acc_r * YEAR_W'(10) + YEAR_W'(dig));
    end else if (pos_r < POS_SEP1) begin
      month_acc_nxt = MON_W'(month_acc_r * MON_W'(10) + MON_W'(dig));
    end else begin
      day_acc_nxt = DAY_W'(day_acc_r * DAY_W'(10) + DAY_W'(dig));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      pos_r       <= '0;
      fmt_bad_r   <= 1'b0;
      year_acc_r  <= '0;
      month_acc_r <= '0;
      day_acc_r   <= '0;
      date_v_r    <= 1'b0;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (consume) begin
        if (in_last_r) begin
          // Start the next string from a clean state
          pos_r       <= '0;
          fmt_bad_r   <= 1'b0;
          year_acc_r  <= '0;
          month_acc_r <= '0;
          day_acc_r   <= '0;
        end else begin
          pos_r       <= pos_nxt;
          fmt_bad_r   <= fmt_bad_nxt;
          year_acc_r  <= year_acc_nxt;
          month_acc_r <= month_acc_nxt;
          day_acc_r   <= day_acc_nxt;
        end
      end
      if (date_free) begin
        date_v_r <= consume && in_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (consume && in_last_r) begin
      date_r.year   <= year_acc_nxt;
      date_r.month  <= month_acc_nxt;
      date_r.day    <= day_acc_nxt;
      date_r.fmt_ok <= !fmt_bad_nxt && (pos_r == POS_LAST);
    end
  end

  assign date_valid = date_v_r;
  assign date       = date_r;

endmodule

`default_nettype wire

### rtl/dscw_calc.sv
// Calendar check and Zeller sum, two register stages.
`default_nettype none

module dscw_calc (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               date_valid,
  output logic                    date_ready,
  input  wire dscw_pkg::date_t    date,
  output logic                    wsum_valid,
  input  wire logic               wsum_ready,
  output dscw_pkg::wsum_t         wsum
);
  import dscw_pkg::*;

  // Stage A: quotients by 100, shifted year and month term
  logic              a_v_r;
  logic [YEAR_W-1:0] a_year_r;
  logic [MON_W-1:0]  a_month_r;
  logic [DAY_W-1:0]  a_day_r;
  logic              a_fmt_r;
  logic [YEAR_W-1:0] a_yy_r;
  logic [7:0]        a_yq_r;
  logic [7:0]        a_yyq_r;
  logic [5:0]        a_mterm_r;

  // Stage B: validity and weekday sum
  logic              b_v_r;
  wsum_t             b_r;

  logic              a_free, b_free;
  logic [YEAR_W-1:0] yy;
  logic [26:0]       y_prod, yy_prod;

  logic              is_cent, is_leap, ok;
  logic [4:0]        limit;
  logic [SUM_W-1:0]  sum;

  assign b_free     = !b_v_r || wsum_ready;
  assign a_free     = !a_v_r || b_free;
  assign date_ready = a_free;

  // January and February belong to the previous year
  assign yy      = (date.month <= MON_FEB) ? YEAR_W'(date.year - YEAR_W'(1)) : date.year;
  assign y_prod  = 27'(date.year) * 27'(DIV100_MUL);
  assign yy_prod = 27'(yy) * 27'(DIV100_MUL);

  always_comb begin
    is_cent = (a_year_r == YEAR_W'(YEAR_W'(a_yq_r) * YEAR_W'(100)));
    is_leap = (a_year_r[1:0] == 2'b00) && (!is_cent || (a_yq_r[1:0] == 2'b00));
    limit   = month_len(a_month_r);
    if (a_month_r == MON_FEB && is_leap) begin
      limit = 5'd29;
    end
    ok = a_fmt_r && (a_year_r != '0) && (a_month_r != '0) && (a_month_r <= MON_DEC)
         && (a_day_r != '0) && (a_day_r <= DAY_W'(limit));
    sum = SUM_W'(a_day_r) + SUM_W'(a_mterm_r) + SUM_W'(a_yy_r) + SUM_W'(a_yy_r >> 2)
          + SUM_W'(a_yyq_r) * SUM_W'(6) + SUM_W'(a_yyq_r >> 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_v_r <= date_valid;
      end
      if (b_free) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && date_valid) begin
      a_year_r  <= date.year;
      a_month_r <= date.month;
      a_day_r   <= date.day;
      a_fmt_r   <= date.fmt_ok;
      a_yy_r    <= yy;
      a_yq_r    <= y_prod[DIV100_SHR +: 8];
      a_yyq_r   <= yy_prod[DIV100_SHR +: 8];
      a_mterm_r <= month_term(date.month);
    end
    if (b_free && a_v_r) begin
      b_r.date_ok <= ok;
      b_r.sum     <= sum;
      b_r.year    <= a_year_r;
      b_r.month   <= a_month_r;
      b_r.day     <= a_day_r;
    end
  end

  assign wsum_valid = b_v_r;
  assign wsum       = b_r;

endmodule

`default_nettype wire

### rtl/dscw_out.sv
// Modulo-7 reduction of the weekday sum and the result register.
`default_nettype none

module dscw_out (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wsum_valid,
  output logic                    wsum_ready,
  input  wire dscw_pkg::wsum_t    wsum,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [31:0]             out_tdata,
  output logic                    out_tuser
);
  import dscw_pkg::*;

  logic             out_v_r;
  logic [31:0]      out_data_r;
  logic             out_user_r;

  logic [29:0]      prod;
  logic [12:0]      q7;
  logic [SUM_W-1:0] rem;
  logic [2:0]       wday;

  assign wsum_ready = !out_v_r || out_tready;

  assign prod = 30'(wsum.sum) * 30'(DIV7_MUL);
  assign q7   = prod[DIV7_SHR +: 13];
  assign rem  = SUM_W'(wsum.sum - SUM_W'(SUM_W'(q7) * SUM_W'(7)));
  assign wday = wsum.date_ok ? rem[2:0] : 3'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (wsum_ready) begin
      out_v_r <= wsum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wsum_ready && wsum_valid) begin
      out_data_r <= {1'b0, wsum.day, wsum.month, wsum.year, wday};
      out_user_r <= wsum.date_ok;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

### rtl/date_string_check_and_weekday.sv
// Top level: date string checker with Zeller weekday output.
`default_nettype none

// Channel   Dir  tdata (low bit up)                              tuser      tlast
// in_       in   [7:0] char_code                                 -          last
// out_      out  [2:0] weekday [16:3] year [23:17] month         valid_res  -
//                [30:24] day [31] zero
//
// Accepts one character per cycle unless a closing character is held back.
// A result passes through the input register, snapshot register, quotient stage,
// sum stage and mod-7 stage, which is the output register. Reset clears the
// parser state and all stage valid bits. Each stage holds while the one after
// it is full and stalled; other characters keep flowing, and only a closing
// character waits in the input register while the snapshot register is full
// and stalled.
module date_string_check_and_weekday (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] char_code
  input  wire logic        in_tlast,    // marks the final character
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [2:0] weekday, [16:3] year, [23:17] month,
                                        // [30:24] day, [31] zero
  output logic             out_tuser    // valid_res
);
  import dscw_pkg::*;

  logic  date_valid, date_ready;
  date_t date;
  logic  wsum_valid, wsum_ready;
  wsum_t wsum;

  // Parse characters, snapshot the fields on the closing character
  dscw_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .date_valid (date_valid),
    .date_ready (date_ready),
    .date       (date)
  );

  // Check the calendar date and build the congruence sum
  dscw_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .date_valid (date_valid),
    .date_ready (date_ready),
    .date       (date),
    .wsum_valid (wsum_valid),
    .wsum_ready (wsum_ready),
    .wsum       (wsum)
  );

  // Reduce modulo 7 and drive the result channel
  dscw_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .wsum_valid (wsum_valid),
    .wsum_ready (wsum_ready),
    .wsum       (wsum),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // No result may be pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A valid date always carries a real weekday
  a_wday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[2:0] != 3'd7)
    else $error("weekday out of range");

  // A rejected date reports weekday zero
  a_wday_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[2:0] == 3'd0)
    else $error("nonzero weekday on invalid date");

  // A valid date has nonzero year, month 1..12 and day 1..31
  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[16:3] != 14'd0) && (out_tdata[23:17] != 7'd0)
      && (out_tdata[23:17] <= 7'd12) && (out_tdata[30:24] != 7'd0)
      && (out_tdata[30:24] <= 7'd31))
    else $error("valid flag on impossible date");

endmodule

`default_nettype wire
